// ----- hw/rtl/cfg_dominator_sets_unit_macros.svh -----
// Assertion macros for the dominator sets checker.
`ifndef CFG_DOMINATOR_SETS_UNIT_MACROS_SVH
`define CFG_DOMINATOR_SETS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDS_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("cds assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("cds assertion failed");

`endif

// ----- hw/rtl/cds_pkg.sv -----
// Shared types and constants of the dominator sets unit.
`timescale 1ns / 1ps
package cds_pkg;
	localparam int DEFAULT_MAX_BLOCKS = 32;
	localparam int ROW_W = 5;
	localparam int DOM_W = 32;
	localparam int TGT_W = 6;

	typedef enum logic [1:0] {
		KIND_FALL = 2'd0,
		KIND_BRANCH = 2'd1,
		KIND_COND = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_INIT,
		ST_ROW,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;
endpackage

// ----- hw/rtl/cds_ram.sv -----
// Simple dual-port synchronous RAM, one write and one registered read port.
`timescale 1ns / 1ps
module cds_ram #(
	parameter int DEPTH = cds_pkg::DEFAULT_MAX_BLOCKS,
	parameter int WIDTH = cds_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- hw/rtl/cfg_dominator_sets_unit.sv -----
// Dominator sets unit: loads a control-flow graph and emits one dominator row per block.
// Load: one block per cycle while in the load state. After the last block the sets are seeded,
// then sweeps run with one read of both memories per predecessor
// candidate, repeated until a sweep changes nothing; then one result row per block is sent.
// Reset clears control state only; both memories are written before any read.
`timescale 1ns / 1ps
module cfg_dominator_sets_unit #(
	parameter int MAX_BLOCKS = cds_pkg::DEFAULT_MAX_BLOCKS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 terminator_kind,
	input  logic signed [cds_pkg::TGT_W-1:0] first_target,
	input  logic signed [cds_pkg::TGT_W-1:0] second_target,
	input  logic                       last_block,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [cds_pkg::ROW_W-1:0]  row_block,
	output logic [cds_pkg::DOM_W-1:0]  dominator_bits,
	output logic                       overflow_flag,
	output logic                       last_row
);
	localparam int W = MAX_BLOCKS;
	localparam int IW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
	localparam logic [CW-1:0] ONE = CW'(1);

	cds_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q, idx_q, b_q, p_q, p_s1;
	logic          ovf_q, vld_s1, chg_q, any_q;
	logic [W-1:0]  acc_q, old_q;

	logic          succ_we, succ_re, dom_we, dom_re;
	logic [IW-1:0] succ_waddr, dom_waddr, dom_raddr;
	logic [W-1:0]  succ_wdata, dom_wdata, succ_rd, dom_rd;

	logic          in_acc, out_free, out_load, issue, hit, row_done, chg_now, last_idx;
	logic [W-1:0]  live, acc_new, old_new, next_row, tgt1_bit, tgt2_bit, fall_bit;
	logic          any_new;

	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign live = ~({W{1'b1}} << count_q);
	assign last_idx = (idx_q == count_q - ONE);

	assign tgt1_bit = first_target[cds_pkg::TGT_W-1] ? '0 : (W'(1) << first_target[4:0]);
	assign tgt2_bit = second_target[cds_pkg::TGT_W-1] ? '0 : (W'(1) << second_target[4:0]);
	assign fall_bit = W'(1) << (count_q + ONE);

	// Row update: AND of dominator rows of every predecessor p, streamed one p a cycle.
	assign issue = (state_q == cds_pkg::ST_ROW) && (p_q < count_q);
	assign hit = vld_s1 && succ_rd[b_q[IW-1:0]];
	assign acc_new = hit ? (acc_q & dom_rd) : acc_q;
	assign any_new = any_q | hit;
	assign old_new = (vld_s1 && (p_s1 == b_q)) ? dom_rd : old_q;
	assign row_done = vld_s1 && (p_s1 == count_q - ONE);
	assign next_row = (any_new ? acc_new : '0) | (W'(1) << b_q);
	assign chg_now = (next_row != old_new);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cds_pkg::ST_LOAD: begin
				if (in_acc && last_block) state_d = cds_pkg::ST_INIT;
			end
			cds_pkg::ST_INIT: begin
				if (last_idx) state_d = (count_q == ONE) ? cds_pkg::ST_EMIT_RD : cds_pkg::ST_ROW;
			end
			cds_pkg::ST_ROW: begin
				if (row_done && (b_q == count_q - ONE) && !(chg_q || chg_now))
					state_d = cds_pkg::ST_EMIT_RD;
			end
			cds_pkg::ST_EMIT_RD: state_d = cds_pkg::ST_EMIT_WR;
			cds_pkg::ST_EMIT_WR: begin
				if (out_free) state_d = last_idx ? cds_pkg::ST_LOAD : cds_pkg::ST_EMIT_RD;
			end
			default: state_d = cds_pkg::ST_LOAD;
		endcase
	end

	// memory and handshake controls
	always_comb begin
		in_stall = 1'b1;
		succ_we = 1'b0;
		succ_waddr = count_q[IW-1:0];
		succ_wdata = '0;
		succ_re = 1'b0;
		dom_we = 1'b0;
		dom_waddr = idx_q[IW-1:0];
		dom_wdata = live;
		dom_re = 1'b0;
		dom_raddr = p_q[IW-1:0];
		out_load = 1'b0;
		case (state_q)
			cds_pkg::ST_LOAD: begin
				in_stall = 1'b0;
				succ_we = in_acc && (count_q < MAXC);
				case (cds_pkg::kind_t'(terminator_kind))
					cds_pkg::KIND_FALL: succ_wdata = fall_bit;
					cds_pkg::KIND_BRANCH: succ_wdata = tgt1_bit;
					cds_pkg::KIND_COND: succ_wdata = tgt1_bit | tgt2_bit;
					default: succ_wdata = '0;
				endcase
			end
			cds_pkg::ST_INIT: begin
				dom_we = 1'b1;
				dom_wdata = (idx_q == '0) ? W'(1) : live;
			end
			cds_pkg::ST_ROW: begin
				succ_re = issue;
				dom_re = issue;
				dom_we = row_done;
				dom_waddr = b_q[IW-1:0];
				dom_wdata = next_row;
			end
			cds_pkg::ST_EMIT_RD: begin
				dom_re = 1'b1;
				dom_raddr = idx_q[IW-1:0];
			end
			cds_pkg::ST_EMIT_WR: out_load = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	cds_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(W)) u_succ (
		.clk(clk), .we(succ_we), .waddr(succ_waddr), .wdata(succ_wdata),
		.re(succ_re), .raddr(p_q[IW-1:0]), .rdata(succ_rd)
	);

	cds_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(W)) u_dom (
		.clk(clk), .we(dom_we), .waddr(dom_waddr), .wdata(dom_wdata),
		.re(dom_re), .raddr(dom_raddr), .rdata(dom_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cds_pkg::ST_LOAD;
			count_q <= '0;
			ovf_q <= 1'b0;
			idx_q <= '0;
			b_q <= '0;
			p_q <= '0;
			vld_s1 <= 1'b0;
			chg_q <= 1'b0;
			any_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1 <= issue;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			case (state_q)
				cds_pkg::ST_LOAD: begin
					idx_q <= '0;
					if (in_acc) begin
						if (count_q < MAXC) count_q <= count_q + ONE;
						else ovf_q <= 1'b1;
					end
				end
				cds_pkg::ST_INIT: begin
					idx_q <= idx_q + ONE;
					b_q <= ONE;
					p_q <= '0;
					chg_q <= 1'b0;
					any_q <= 1'b0;
					if (last_idx) idx_q <= '0;
				end
				cds_pkg::ST_ROW: begin
					if (issue) p_q <= p_q + ONE;
					if (row_done) begin
						any_q <= 1'b0;
						p_q <= '0;
						if (b_q == count_q - ONE) begin
							b_q <= ONE;
							chg_q <= 1'b0;
						end else begin
							b_q <= b_q + ONE;
							chg_q <= chg_q | chg_now;
						end
					end else begin
						any_q <= any_new;
					end
				end
				cds_pkg::ST_EMIT_WR: begin
					if (out_free) begin
						idx_q <= idx_q + ONE;
						if (last_idx) begin
							count_q <= '0;
							ovf_q <= 1'b0;
						end
					end
				end
				default: idx_q <= idx_q;
			endcase
		end
	end

	// datapath registers without reset
	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		if (state_q == cds_pkg::ST_INIT || row_done) acc_q <= live;
		else if (state_q == cds_pkg::ST_ROW) acc_q <= acc_new;
		if (state_q == cds_pkg::ST_ROW) old_q <= old_new;
		if (out_load) begin
			row_block <= cds_pkg::ROW_W'(idx_q);
			dominator_bits <= cds_pkg::DOM_W'(dom_rd);
			overflow_flag <= ovf_q;
			last_row <= last_idx;
		end
	end
endmodule

// ----- hw/rtl/cds_checker.sv -----
// Port-level checker for the dominator sets unit, bound to the top level.
`timescale 1ns / 1ps
`include "cfg_dominator_sets_unit_macros.svh"
module cds_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      last_block,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [cds_pkg::ROW_W-1:0] row_block,
	input logic [cds_pkg::DOM_W-1:0] dominator_bits,
	input logic                      last_row
);
	// a stalled result holds
	`CDS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(row_block) && $stable(dominator_bits))
	// no loading while rows of a graph remain to be sent
	`CDS_ASSERT_IMPL(a_no_load_mid_emit, clk, arst_n, out_valid && !last_row, in_stall)
	// the final block starts the computation and closes the input
	`CDS_ASSERT_NEXT(a_last_closes, clk, arst_n, in_valid && !in_stall && last_block, in_stall)
endmodule

bind cfg_dominator_sets_unit cds_checker u_cds_checker (.*);
